/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Implication checks used at the end of next_prime_finder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/npf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npf_pkg
// Word types, state encoding and unit status for the next-prime search.
// ----------------------------------------------------------------------------
package npf_pkg;

	localparam int FIELD_W = 32;

	typedef struct packed {
		logic [FIELD_W-1:0] start_value;
		logic               strictly_above;
	} npf_in_t;

	typedef struct packed {
		logic [FIELD_W-1:0] found_prime;
		logic               out_of_range;
	} npf_out_t;

	typedef struct packed {
		logic done;
		logic zero;
	} npf_rem_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_CAND,
		ST_TEST,
		ST_DIV
	} npf_state_t;

endpackage

/* rtl/core/npf_rem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npf_rem
// Bit-serial remainder unit: shifts the dividend in MSB first, one bit per
// cycle, with a restoring compare-subtract against the divisor.
// ----------------------------------------------------------------------------
module npf_rem #(
	parameter int NW = 32,
	parameter int DW = 18
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  logic [NW-1:0]          dividend,
	input  logic [DW-1:0]          divisor,
	output npf_pkg::npf_rem_stat_t stat
);

	localparam int CNW = (NW > 1) ? $clog2(NW) : 1;

	logic [NW-1:0]  sh_q;
	logic [DW-1:0]  rem_q;
	logic [CNW-1:0] cnt_q;
	logic           run_q;
	logic           done_q;
	logic [DW:0]    trial;
	logic [DW:0]    diff;
	logic [DW-1:0]  rem_next;

	assign trial    = {rem_q, sh_q[NW-1]};
	assign diff     = trial - {1'b0, divisor};
	assign rem_next = (trial >= {1'b0, divisor}) ? diff[DW-1:0] : trial[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == '0);
			if (load)
				run_q <= 1'b1;
			else if (run_q && (cnt_q == '0))
				run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q  <= dividend;
			rem_q <= '0;
			cnt_q <= CNW'(NW - 1);
		end else if (run_q) begin
			sh_q  <= {sh_q[NW-2:0], 1'b0};
			rem_q <= rem_next;
			cnt_q <= cnt_q - CNW'(1);
		end
	end

	assign stat.done = done_q;
	assign stat.zero = (rem_q == '0);

endmodule

/* rtl/core/next_prime_finder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// next_prime_finder
// Smallest prime at or above (or strictly above) a start value by trial
// division with odd divisors, remainders taken one dividend bit per cycle.
// ----------------------------------------------------------------------------
// Sequence: done is registered from the finishing state; small starts and
// starts past the ceiling finish in INIT. Otherwise each trial divisor takes
// a TEST state and a remainder pass in DIV, each candidate a CAND state, and
// the prime a final TEST, with CW = min(WIDTH, 32) bits per remainder pass.
// One word at a time: start is taken again in the cycle that done is high.
// Reset clears the controller; the result strobe cannot be stalled.
`include "assert_macros.svh"

module next_prime_finder #(
	parameter int WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  npf_pkg::npf_in_t  cmd,
	output logic              busy,
	output logic              done,
	output npf_pkg::npf_out_t rsp
);

	localparam int CW  = (WIDTH > npf_pkg::FIELD_W) ? npf_pkg::FIELD_W : WIDTH;
	localparam int DW  = CW / 2 + 2;
	localparam int DSW = CW + 2;
	localparam logic [CW:0] CEIL = {1'b0, {CW{1'b1}}};
	localparam logic [npf_pkg::FIELD_W-1:0] CEIL_F = npf_pkg::FIELD_W'(CEIL);

	npf_pkg::npf_state_t    state_q, state_d;
	npf_pkg::npf_rem_stat_t stat;

	logic [npf_pkg::FIELD_W-1:0] s_q;
	logic                        above_q;
	logic [CW:0]                 n_q;
	logic [DW-1:0]               d_q;
	logic [DSW-1:0]              dsq_q;
	npf_pkg::npf_out_t           res_q;
	logic                        done_q;

	logic [CW:0]                 t_val;
	logic                        fin;
	logic                        fin_oor;
	logic [CW:0]                 fin_val;
	logic                        rem_load;

	assign t_val = {1'b0, s_q[CW-1:0]} + (CW+1)'(above_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= npf_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		fin      = 1'b0;
		fin_oor  = 1'b0;
		fin_val  = '0;
		rem_load = 1'b0;
		case (state_q)
			npf_pkg::ST_IDLE: begin
				if (start)
					state_d = npf_pkg::ST_INIT;
			end
			npf_pkg::ST_INIT: begin
				if ((s_q > CEIL_F) || (above_q && (s_q == CEIL_F))) begin
					fin     = 1'b1;
					fin_oor = 1'b1;
					state_d = npf_pkg::ST_IDLE;
				end else if (t_val <= (CW+1)'(2)) begin
					fin     = 1'b1;
					fin_val = (CW+1)'(2);
					state_d = npf_pkg::ST_IDLE;
				end else begin
					state_d = npf_pkg::ST_CAND;
				end
			end
			npf_pkg::ST_CAND: begin
				if (n_q > CEIL) begin
					fin     = 1'b1;
					fin_oor = 1'b1;
					state_d = npf_pkg::ST_IDLE;
				end else begin
					state_d = npf_pkg::ST_TEST;
				end
			end
			npf_pkg::ST_TEST: begin
				if (dsq_q > DSW'(n_q)) begin
					fin     = 1'b1;
					fin_val = n_q;
					state_d = npf_pkg::ST_IDLE;
				end else begin
					rem_load = 1'b1;
					state_d  = npf_pkg::ST_DIV;
				end
			end
			npf_pkg::ST_DIV: begin
				if (stat.done)
					state_d = stat.zero ? npf_pkg::ST_CAND : npf_pkg::ST_TEST;
			end
			default: begin
				state_d = npf_pkg::ST_IDLE;
			end
		endcase
	end

	// Datapath: start word, candidate, divisor and its square
	always_ff @(posedge clk) begin
		case (state_q)
			npf_pkg::ST_IDLE: begin
				if (start) begin
					s_q     <= cmd.start_value;
					above_q <= cmd.strictly_above;
				end
			end
			npf_pkg::ST_INIT: begin
				n_q <= t_val | (CW+1)'(1);
			end
			npf_pkg::ST_CAND: begin
				d_q   <= DW'(3);
				dsq_q <= DSW'(9);
			end
			npf_pkg::ST_DIV: begin
				if (stat.done) begin
					if (stat.zero) begin
						n_q <= n_q + (CW+1)'(2);
					end else begin
						d_q   <= d_q + DW'(2);
						dsq_q <= dsq_q + DSW'({d_q, 2'b00}) + DSW'(4);
					end
				end
			end
			default: begin
			end
		endcase
		if (fin) begin
			res_q.found_prime  <= npf_pkg::FIELD_W'(fin_val[CW-1:0]);
			res_q.out_of_range <= fin_oor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= fin;
	end

	npf_rem #(
		.NW(CW),
		.DW(DW)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (rem_load),
		.dividend (n_q[CW-1:0]),
		.divisor  (d_q),
		.stat     (stat)
	);

	assign busy = (state_q != npf_pkg::ST_IDLE);
	assign done = done_q;
	assign rsp  = res_q;

	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_IMPLY(a_done_idle, clk, arst_n, done, !busy)
	`ASSERT_IMPLY(a_oor_zero, clk, arst_n, done && rsp.out_of_range, rsp.found_prime == '0)
	`ASSERT_IMPLY(a_prime_odd, clk, arst_n, done && !rsp.out_of_range, rsp.found_prime[0] || (rsp.found_prime == npf_pkg::FIELD_W'(2)))
	`ASSERT_IMPLY(a_div_only, clk, arst_n, stat.done, state_q == npf_pkg::ST_DIV)

endmodule

/* verif/tb_next_prime_finder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_next_prime_finder
// Self-checking bench for the trial-division next-prime search. A queue of
// search words, directed corners first and then random values mostly kept
// small, feeds a start/busy driver with random idle cycles. Each accepted
// word is predicted in the bench and every done strobe is checked in order.
// ----------------------------------------------------------------------------
module tb_next_prime_finder;

	localparam int WIDTH        = 32;
	localparam int CLK_HALF     = 5;
	localparam int RANDOM_WORDS = 80;
	localparam int DRAIN_CYCLES = 50;
	localparam longint unsigned CYCLE_LIMIT = 20_000_000;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	npf_pkg::npf_in_t  cmd    = '0;
	logic              busy;
	logic              done;
	npf_pkg::npf_out_t rsp;

	npf_pkg::npf_in_t  search_words[$];
	npf_pkg::npf_out_t expected_primes[$];
	npf_pkg::npf_out_t want;
	int                words_taken = 0;
	int                words_directed;
	int                results_checked = 0;
	int                oor_results = 0;
	int                mismatches = 0;
	longint unsigned   cycle_count = 0;

	next_prime_finder #(.WIDTH(WIDTH)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	always #CLK_HALF clk = ~clk;

	// smallest prime at or above the start (strictly above when flagged)
	function automatic npf_pkg::npf_out_t next_prime_of(npf_pkg::npf_in_t w);
		longint unsigned ceiling, n, d;
		bit found, composite;
		npf_pkg::npf_out_t r;
		ceiling = (64'd1 << ((WIDTH > npf_pkg::FIELD_W) ? npf_pkg::FIELD_W : WIDTH)) - 1;
		n = 64'(w.start_value);
		found = 1'b0;
		if (n <= ceiling && !(w.strictly_above && n == ceiling)) begin
			if (w.strictly_above)
				n = n + 1;
			if (n <= 2) begin
				n = 2;
				found = (n <= ceiling);
			end else begin
				if ((n & 1) == 0)
					n = n + 1;
				while (!found && n <= ceiling) begin
					composite = 1'b0;
					for (d = 3; d * d <= n && !composite; d += 2)
						if (n % d == 0)
							composite = 1'b1;
					if (composite)
						n = n + 2;
					else
						found = 1'b1;
				end
			end
		end
		r.found_prime  = found ? npf_pkg::FIELD_W'(n) : '0;
		r.out_of_range = !found;
		return r;
	endfunction

	task automatic add_word(input logic [npf_pkg::FIELD_W-1:0] value, input logic above);
		npf_pkg::npf_in_t w;
		w.start_value    = value;
		w.strictly_above = above;
		search_words.push_back(w);
	endtask

	// driver: hold a word until taken, idle now and then outside the quiet stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd   <= '0;
		end else begin
			if (start && !busy) begin
				expected_primes.push_back(next_prime_of(cmd));
				words_taken++;
			end
			if (!start || !busy) begin
				if (search_words.size() > 0 &&
				    ((words_taken >= 40 && words_taken < 70) || $urandom_range(99) >= 7)) begin
					start <= 1'b1;
					cmd   <= search_words.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every strobe must match the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_primes.size() == 0) begin
				$display("%0t: unexpected result found_prime %0d out_of_range %0b",
				         $time, rsp.found_prime, rsp.out_of_range);
				mismatches++;
			end else begin
				want = expected_primes.pop_front();
				results_checked++;
				if (want.out_of_range)
					oor_results++;
				if (rsp.found_prime !== want.found_prime) begin
					$display("%0t: found_prime expected %0d got %0d",
					         $time, want.found_prime, rsp.found_prime);
					mismatches++;
				end
				if (rsp.out_of_range !== want.out_of_range) begin
					$display("%0t: out_of_range expected %0b got %0b",
					         $time, want.out_of_range, rsp.out_of_range);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d words pending and %0d results outstanding",
			         $time, search_words.size(), expected_primes.size());
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int sel;
		add_word(32'd0, 1'b0);
		add_word(32'd0, 1'b1);
		add_word(32'd1, 1'b0);
		add_word(32'd1, 1'b1);
		add_word(32'd2, 1'b0);
		add_word(32'd2, 1'b1);
		add_word(32'd3, 1'b0);
		add_word(32'd3, 1'b1);
		add_word(32'd4, 1'b0);
		add_word(32'd9, 1'b0);
		add_word(32'd13, 1'b1);
		add_word(32'd24, 1'b1);
		add_word(32'd89, 1'b1);
		add_word(32'd65521, 1'b0);
		add_word(32'd65535, 1'b0);
		add_word(32'd65536, 1'b1);
		add_word(32'd1000000, 1'b1);
		add_word(32'd1000003, 1'b0);
		add_word(32'hFFFF_FFFF, 1'b0);
		add_word(32'hFFFF_FFFF, 1'b1);
		add_word(32'd4294967291, 1'b1);
		words_directed = search_words.size();

		repeat (RANDOM_WORDS) begin
			sel = $urandom_range(99);
			if (sel < 70)
				add_word($urandom_range(2000), 1'($urandom_range(1)));
			else if (sel < 97)
				add_word($urandom_range(16'hFFFF), 1'($urandom_range(1)));
			else
				add_word($urandom_range(24'hFF_FFFF), 1'($urandom_range(1)));
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// sample away from the driving edge so queue and start have settled
		while (search_words.size() != 0 || start || expected_primes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Searched %0d start words (%0d directed corners, rest random), %0d results",
		         words_taken, words_directed, results_checked);
		$display("checked, %0d of them out of range, in %0d cycles",
		         oor_results, cycle_count);
		if (mismatches == 0 && expected_primes.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
